// ===== hw/rtl/dq_pkg.sv =====
// Package for the bounded deque core: sizes, command and status codes,
// and the control word broadcast to the cell row. No dependencies.
package dq_pkg;

  // Store size and field widths
  localparam int unsigned DqCapacity = 16;
  localparam int unsigned IdxW       = $clog2(DqCapacity);
  localparam int unsigned CntW       = 5;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned StatusW    = 2;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_CLEAR      = 3'd7
  } dq_cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  // What every cell does in one update
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } dq_cell_op_e;

  // Control word broadcast to all cells
  typedef struct packed {
    logic                     en;
    dq_cell_op_e              op;
    logic [CntW-1:0]          pos;
    logic signed [WordW-1:0]  value;
    logic [CntW-1:0]          rd_pos;
    logic [CntW-1:0]          back_pos;
  } dq_ctrl_t;

  // Word returned on an error
  localparam logic signed [WordW-1:0] ErrWord = 32'sd1;

endpackage

// ===== hw/rtl/dq_in_if.sv =====
// Command channel of the deque core: valid/ready plus one command beat.
// Depends on dq_pkg.
interface dq_in_if;
  import dq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic [CntW-1:0]         position;
  logic signed [WordW-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== hw/rtl/dq_out_if.sv =====
// Result channel of the deque core: valid/ready plus one result beat.
// Depends on dq_pkg.
interface dq_out_if;
  import dq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] data;
  logic [StatusW-1:0]      status;
  logic [CntW-1:0]         count;
  logic signed [WordW-1:0] front_value;
  logic signed [WordW-1:0] back_value;

  modport source (output valid, output data, output status, output count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input data, input status, input count,
                  input front_value, input back_value, output ready);
endinterface

// ===== hw/rtl/dq_cell.sv =====
// One storage cell of the deque row: holds one element, shifts to or from
// its neighbors and taps its value for reads. Depends on dq_pkg.
module dq_cell #(
  parameter logic [dq_pkg::IdxW-1:0] Index = '0
) (
  input  logic                           clk_i,
  input  dq_pkg::dq_ctrl_t               ctrl_i,
  input  logic signed [dq_pkg::WordW-1:0] left_i,
  input  logic signed [dq_pkg::WordW-1:0] right_i,
  output logic signed [dq_pkg::WordW-1:0] value_o,
  output logic signed [dq_pkg::WordW-1:0] next_o,
  output logic signed [dq_pkg::WordW-1:0] rd_o,
  output logic signed [dq_pkg::WordW-1:0] back_o
);
  import dq_pkg::*;

  logic signed [WordW-1:0] slot_q, slot_d;
  logic [CntW-1:0]         my_pos;
  logic                    below, at_pos;

  assign my_pos = CntW'(Index);
  assign below  = my_pos < ctrl_i.pos;
  assign at_pos = my_pos == ctrl_i.pos;

  // Pick the next value: hold, open a gap at pos, or close the gap at pos
  always_comb begin
    unique case (ctrl_i.op)
      OP_OPEN: begin
        if (below) begin
          slot_d = slot_q;
        end else if (at_pos) begin
          slot_d = ctrl_i.value;
        end else begin
          slot_d = left_i;
        end
      end
      OP_CLOSE: begin
        if (below) begin
          slot_d = slot_q;
        end else begin
          slot_d = right_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  // Store the element on an accepted command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      slot_q <= slot_d;
    end
  end

  // Drive neighbor and tap outputs; taps read zero unless selected
  assign value_o = slot_q;
  assign next_o  = slot_d;
  assign rd_o    = (my_pos == ctrl_i.rd_pos) ? slot_q : '0;
  assign back_o  = (my_pos == ctrl_i.back_pos) ? slot_d : '0;

endmodule

// ===== hw/rtl/bounded_deque_with_positional_ops_core.sv =====
// Bounded deque core: a row of shifting cells plus command decode and a
// result register. The result is valid the cycle after the command beat
// and one command per cycle is taken while results are drained.
// Reset clears the element count and the result valid; cell contents are
// left as they are and never read outside the occupied part.
module bounded_deque_with_positional_ops_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    req_i,
  dq_out_if.source rsp_o
);
  import dq_pkg::*;

  localparam int unsigned Last = DqCapacity - 1;

  logic [CntW-1:0]         count_q, count_d;
  logic                    accept;
  logic                    full, empty;
  dq_cmd_e                 cmd;
  dq_ctrl_t                ctrl;
  dq_status_e              status;
  logic                    take_rd;
  logic                    err;
  logic signed [WordW-1:0] data, front, back, rd_word, back_word;

  logic signed [WordW-1:0] value_w [DqCapacity];
  logic signed [WordW-1:0] next_w  [DqCapacity];
  logic signed [WordW-1:0] rd_w    [DqCapacity];
  logic signed [WordW-1:0] back_w  [DqCapacity];

  logic                    valid_q;
  logic signed [WordW-1:0] data_q, front_q, back_q;
  logic [StatusW-1:0]      status_q;
  logic [CntW-1:0]         cnt_out_q;

  // Take a command whenever the result register is free or draining
  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign cmd   = dq_cmd_e'(req_i.cmd);
  assign full  = count_q == CntW'(DqCapacity);
  assign empty = count_q == '0;

  // Decode the command into a cell operation, status and new count
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.pos    = req_i.position;
    ctrl.value  = req_i.value;
    ctrl.rd_pos = req_i.position;
    status      = ST_OK;
    take_rd     = 1'b0;
    count_d     = count_q;
    unique case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op  = OP_OPEN;
          ctrl.pos = (cmd == CMD_PUSH_BACK) ? count_q : '0;
          count_d  = count_q + CntW'(1);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        ctrl.pos    = (cmd == CMD_POP_BACK) ? count_q - CntW'(1) : '0;
        ctrl.rd_pos = ctrl.pos;
        if (empty) begin
          status = ST_RANGE;
        end else begin
          ctrl.op = OP_CLOSE;
          take_rd = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (req_i.position > count_q) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = OP_OPEN;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (req_i.position >= count_q) begin
          status = ST_RANGE;
        end else begin
          ctrl.op = OP_CLOSE;
          take_rd = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      CMD_READ: begin
        if (req_i.position >= count_q) begin
          status = ST_RANGE;
        end else begin
          take_rd = 1'b1;
        end
      end
      CMD_CLEAR: count_d = '0;
      default:   status  = ST_OK;
    endcase
    ctrl.en       = accept;
    ctrl.back_pos = count_d - CntW'(1);
  end

  // Build the cell row, each cell fed by its two neighbors
  for (genvar i = 0; i < DqCapacity; i++) begin : g_cell
    logic signed [WordW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = value_w[i-1];
    end
    if (i == Last) begin : g_last
      assign right = value_w[i];
    end else begin : g_inner_r
      assign right = value_w[i+1];
    end
    dq_cell #(
      .Index(IdxW'(i))
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .value_o(value_w[i]),
      .next_o (next_w[i]),
      .rd_o   (rd_w[i]),
      .back_o (back_w[i])
    );
  end

  // Merge the cell taps; only the selected cell drives a nonzero word
  always_comb begin
    rd_word   = '0;
    back_word = '0;
    for (int i = 0; i < DqCapacity; i++) begin
      rd_word   = rd_word | rd_w[i];
      back_word = back_word | back_w[i];
    end
  end

  // Form the result fields
  assign err   = status != ST_OK;
  assign data  = err ? ErrWord : (take_rd ? rd_word : '0);
  assign front = (count_d == '0) ? ErrWord : next_w[0];
  assign back  = (count_d == '0) ? ErrWord : back_word;

  // Advance the element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= data;
      status_q  <= status;
      cnt_out_q <= count_d;
      front_q   <= front;
      back_q    <= back;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.data        = data_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.count       = cnt_out_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;

endmodule
